// ----- hdl/ceu_pkg.sv -----
// package: types, op codes and sizes for the complex elementwise alu
`timescale 1ns / 1ps
`default_nettype none
package ceu_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  // products are 2*DataWidth, sums of two products one more bit
  localparam int ProdWidth = 2 * DataWidth;
  localparam int SumWidth  = ProdWidth + 1;
  // dividend carries the fraction shift
  localparam int NumWidth  = SumWidth + FracBits;
  localparam int QuoWidth  = NumWidth;

  typedef enum logic [2:0] {
    OpCadd = 3'd0,
    OpCsub = 3'd1,
    OpCmul = 3'd2,
    OpCdiv = 3'd3,
    OpRadd = 3'd4,
    OpRsub = 3'd5,
    OpRmul = 3'd6,
    OpRdiv = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk  = 2'd0,
    StSat = 2'd1,
    StDz  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                  op;
    logic signed [DataWidth-1:0] a_re;
    logic signed [DataWidth-1:0] a_im;
    logic signed [DataWidth-1:0] b_re;
    logic signed [DataWidth-1:0] b_im;
    logic                        last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] out_re;
    logic signed [DataWidth-1:0] out_im;
    logic [1:0]                  status;
    logic                        last_out;
  } out_item_t;

  // control that travels with each item through the pipeline
  typedef struct packed {
    op_e  op;
    logic dz;
    logic last;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hdl/ceu_front.sv -----
// front stages: products, then sums, shifts and divisor for each op
`timescale 1ns / 1ps
`default_nettype none
module ceu_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire ceu_pkg::in_item_t                     item_i,
  output logic                                       valid_o,
  output ceu_pkg::ctl_t                              ctl_o,
  output logic signed [ceu_pkg::NumWidth-1:0]        num_re_o,
  output logic signed [ceu_pkg::NumWidth-1:0]        num_im_o,
  output logic signed [ceu_pkg::SumWidth-1:0]        den_o
);
  import ceu_pkg::*;

  // stage one registers: six products and pass-through operands
  logic                        v1_q;
  ctl_t                        ctl1_q, ctl1_d;
  logic signed [ProdWidth-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bb_r_q, p_bb_i_q;
  logic signed [DataWidth-1:0] a_re1_q, a_im1_q, b_re1_q, b_im1_q;

  // stage two registers
  logic                        v2_q;
  ctl_t                        ctl2_q;
  logic signed [NumWidth-1:0]  num_re_q, num_im_q, num_re_d, num_im_d;
  logic signed [SumWidth-1:0]  den_q, den_d;

  // decode op and divide by zero
  always_comb begin
    ctl1_d.op   = op_e'(item_i.op);
    ctl1_d.last = item_i.last_in;
    ctl1_d.dz   = 1'b0;
    if (op_e'(item_i.op) == OpCdiv)
      ctl1_d.dz = (item_i.b_re == '0) && (item_i.b_im == '0);
    else if (op_e'(item_i.op) == OpRdiv)
      ctl1_d.dz = (item_i.b_re == '0);
  end

  // stage one and stage two valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage one multiplies
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl1_q   <= ctl1_d;
      p_rr_q   <= item_i.a_re * item_i.b_re;
      p_ii_q   <= item_i.a_im * item_i.b_im;
      p_ir_q   <= item_i.a_im * item_i.b_re;
      p_ri_q   <= item_i.a_re * item_i.b_im;
      p_bb_r_q <= item_i.b_re * item_i.b_re;
      p_bb_i_q <= item_i.b_im * item_i.b_im;
      a_re1_q  <= item_i.a_re;
      a_im1_q  <= item_i.a_im;
      b_re1_q  <= item_i.b_re;
      b_im1_q  <= item_i.b_im;
    end
  end

  // stage two sums, shifts and divisor select
  always_comb begin
    logic signed [SumWidth-1:0] s_re, s_im;
    num_re_d = '0;
    num_im_d = '0;
    den_d    = SumWidth'(1);
    s_re     = '0;
    s_im     = '0;
    unique case (ctl1_q.op)
      OpCadd: begin
        num_re_d = NumWidth'(a_re1_q) + NumWidth'(b_re1_q);
        num_im_d = NumWidth'(a_im1_q) + NumWidth'(b_im1_q);
      end
      OpCsub: begin
        num_re_d = NumWidth'(a_re1_q) - NumWidth'(b_re1_q);
        num_im_d = NumWidth'(a_im1_q) - NumWidth'(b_im1_q);
      end
      OpCmul: begin
        s_re     = SumWidth'(p_rr_q) - SumWidth'(p_ii_q);
        s_im     = SumWidth'(p_ir_q) + SumWidth'(p_ri_q);
        num_re_d = NumWidth'(s_re >>> FracBits);
        num_im_d = NumWidth'(s_im >>> FracBits);
      end
      OpCdiv: begin
        s_re     = SumWidth'(p_rr_q) + SumWidth'(p_ii_q);
        s_im     = SumWidth'(p_ir_q) - SumWidth'(p_ri_q);
        num_re_d = NumWidth'(s_re) <<< FracBits;
        num_im_d = NumWidth'(s_im) <<< FracBits;
        den_d    = SumWidth'(p_bb_r_q) + SumWidth'(p_bb_i_q);
      end
      OpRadd: begin
        num_re_d = NumWidth'(a_re1_q) + NumWidth'(b_re1_q);
        num_im_d = NumWidth'(a_im1_q);
      end
      OpRsub: begin
        num_re_d = NumWidth'(a_re1_q) - NumWidth'(b_re1_q);
        num_im_d = NumWidth'(a_im1_q);
      end
      OpRmul: begin
        num_re_d = NumWidth'(p_rr_q >>> FracBits);
        num_im_d = NumWidth'(p_ir_q >>> FracBits);
      end
      OpRdiv: begin
        num_re_d = NumWidth'(a_re1_q) <<< FracBits;
        num_im_d = NumWidth'(a_im1_q) <<< FracBits;
        den_d    = SumWidth'(b_re1_q);
      end
      default: ;
    endcase
    // divide by zero leaves divisor at one so the divider is harmless
    if (ctl1_q.dz) den_d = SumWidth'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl2_q   <= ctl1_q;
      num_re_q <= num_re_d;
      num_im_q <= num_im_d;
      den_q    <= den_d;
    end
  end

  assign valid_o  = v2_q;
  assign ctl_o    = ctl2_q;
  assign num_re_o = num_re_q;
  assign num_im_o = num_im_q;
  assign den_o    = den_q;
endmodule
`default_nettype wire

// ----- hdl/ceu_div.sv -----
// pipelined signed divider, one quotient bit per stage, truncates toward zero
`timescale 1ns / 1ps
`default_nettype none
module ceu_div (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire ceu_pkg::ctl_t                         ctl_i,
  input  wire logic signed [ceu_pkg::NumWidth-1:0]   num_re_i,
  input  wire logic signed [ceu_pkg::NumWidth-1:0]   num_im_i,
  input  wire logic signed [ceu_pkg::SumWidth-1:0]   den_i,
  output logic                                       valid_o,
  output ceu_pkg::ctl_t                              ctl_o,
  output logic signed [ceu_pkg::QuoWidth-1:0]        re_o,
  output logic signed [ceu_pkg::QuoWidth-1:0]        im_o
);
  import ceu_pkg::*;

  localparam int Steps = NumWidth;
  localparam int RemWidth = SumWidth + 1;

  // one row per stage: magnitudes shift left, remainder grows by a bit
  logic                 v_q    [Steps+1];
  ctl_t                 ctl_q  [Steps+1];
  logic                 div_q  [Steps+1];
  logic                 nre_q  [Steps+1];
  logic                 nim_q  [Steps+1];
  logic [NumWidth-1:0]  nmre_q [Steps+1];
  logic [NumWidth-1:0]  nmim_q [Steps+1];
  logic [RemWidth-1:0]  rre_q  [Steps+1];
  logic [RemWidth-1:0]  rim_q  [Steps+1];
  logic [SumWidth-1:0]  d_q    [Steps+1];

  logic                 is_div;
  logic                 dneg;
  logic [SumWidth-1:0]  dmag;

  // entry: take magnitudes for divide ops; other ops pass through the array unchanged
  always_comb begin
    is_div = (ctl_i.op == OpCdiv) || (ctl_i.op == OpRdiv);
    dneg   = den_i[SumWidth-1];
    dmag   = dneg ? SumWidth'(-den_i) : SumWidth'(den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q[0]  <= ctl_i;
      div_q[0]  <= is_div;
      nre_q[0]  <= is_div && (num_re_i[NumWidth-1] != dneg);
      nim_q[0]  <= is_div && (num_im_i[NumWidth-1] != dneg);
      nmre_q[0] <= !is_div ? NumWidth'(num_re_i) :
                   num_re_i[NumWidth-1] ? NumWidth'(-num_re_i) : NumWidth'(num_re_i);
      nmim_q[0] <= !is_div ? NumWidth'(num_im_i) :
                   num_im_i[NumWidth-1] ? NumWidth'(-num_im_i) : NumWidth'(num_im_i);
      rre_q[0]  <= '0;
      rim_q[0]  <= '0;
      d_q[0]    <= dmag;
    end
  end

  // restoring step per stage, quotient bits shift into the low end
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemWidth-1:0] tre, tim;
    logic                gre, gim;
    always_comb begin
      tre = {rre_q[s][RemWidth-2:0], nmre_q[s][NumWidth-1]};
      tim = {rim_q[s][RemWidth-2:0], nmim_q[s][NumWidth-1]};
      gre = tre >= RemWidth'(d_q[s]);
      gim = tim >= RemWidth'(d_q[s]);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[s+1] <= ctl_q[s];
        div_q[s+1] <= div_q[s];
        nre_q[s+1] <= nre_q[s];
        nim_q[s+1] <= nim_q[s];
        d_q[s+1]   <= d_q[s];
        if (div_q[s]) begin
          nmre_q[s+1] <= {nmre_q[s][NumWidth-2:0], gre};
          nmim_q[s+1] <= {nmim_q[s][NumWidth-2:0], gim};
          rre_q[s+1]  <= gre ? tre - RemWidth'(d_q[s]) : tre;
          rim_q[s+1]  <= gim ? tim - RemWidth'(d_q[s]) : tim;
        end else begin
          nmre_q[s+1] <= nmre_q[s];
          nmim_q[s+1] <= nmim_q[s];
          rre_q[s+1]  <= rre_q[s];
          rim_q[s+1]  <= rim_q[s];
        end
      end
    end
  end

  // sign fix-up on the way out
  assign valid_o = v_q[Steps];
  assign ctl_o   = ctl_q[Steps];
  assign re_o    = nre_q[Steps] ? -$signed(nmre_q[Steps]) : $signed(nmre_q[Steps]);
  assign im_o    = nim_q[Steps] ? -$signed(nmim_q[Steps]) : $signed(nmim_q[Steps]);
endmodule
`default_nettype wire

// ----- hdl/ceu_sat.sv -----
// last stage: saturation, status and output register
`timescale 1ns / 1ps
`default_nettype none
module ceu_sat (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire ceu_pkg::ctl_t                         ctl_i,
  input  wire logic signed [ceu_pkg::QuoWidth-1:0]   re_i,
  input  wire logic signed [ceu_pkg::QuoWidth-1:0]   im_i,
  output logic                                       valid_o,
  output ceu_pkg::out_item_t                         item_o
);
  import ceu_pkg::*;

  localparam logic signed [QuoWidth-1:0] MaxV = QuoWidth'({1'b0, {(DataWidth-1){1'b1}}});
  localparam logic signed [QuoWidth-1:0] MinV = -MaxV - QuoWidth'(1);

  logic      v_q;
  out_item_t item_q, item_d;
  logic      ovf_re, ovf_im;

  // clamp each part and build status
  always_comb begin
    ovf_re = (re_i > MaxV) || (re_i < MinV);
    ovf_im = (im_i > MaxV) || (im_i < MinV);
    item_d.out_re   = re_i > MaxV ? DataWidth'(MaxV) :
                      re_i < MinV ? DataWidth'(MinV) : DataWidth'(re_i);
    item_d.out_im   = im_i > MaxV ? DataWidth'(MaxV) :
                      im_i < MinV ? DataWidth'(MinV) : DataWidth'(im_i);
    item_d.status   = (ovf_re || ovf_im) ? StSat : StOk;
    item_d.last_out = ctl_i.last;
    if (ctl_i.dz) begin
      item_d.out_re = '0;
      item_d.out_im = '0;
      item_d.status = StDz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_q <= item_d;
  end

  assign valid_o = v_q;
  assign item_o  = item_q;
endmodule
`default_nettype wire

// ----- hdl/complex_elementwise_alu_core.sv -----
// top level: complex elementwise alu pipeline
//
// channel   direction  handshake           payload
// in        input      in_valid_i/in_ready_o    in_item_i  (ceu_pkg::in_item_t)
// out       output     out_valid_o/out_ready_i  out_item_o (ceu_pkg::out_item_t)
//
// one transfer per cycle in both directions when not stalled; results pass
// through the front stages, the divider entry and steps, and the output register.
// every op runs through the same stages so results stay in order.
// the whole pipeline advances together; it stalls only when the output holds
// a result that is not taken, and a stall freezes every stage, bubbles included.
// reset clears all valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module complex_elementwise_alu_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ceu_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ceu_pkg::out_item_t      out_item_o
);
  import ceu_pkg::*;

  logic                       en;
  logic                       fv, dv;
  ctl_t                       fctl, dctl;
  logic signed [NumWidth-1:0] num_re, num_im;
  logic signed [SumWidth-1:0] den;
  logic signed [QuoWidth-1:0] q_re, q_im;

  // advance whenever the output slot is free or being taken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  ceu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .item_i   (in_item_i),
    .valid_o  (fv),
    .ctl_o    (fctl),
    .num_re_o (num_re),
    .num_im_o (num_im),
    .den_o    (den)
  );

  ceu_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (fv),
    .ctl_i    (fctl),
    .num_re_i (num_re),
    .num_im_i (num_im),
    .den_i    (den),
    .valid_o  (dv),
    .ctl_o    (dctl),
    .re_o     (q_re),
    .im_o     (q_im)
  );

  ceu_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .ctl_i   (dctl),
    .re_i    (q_re),
    .im_i    (q_im),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );
endmodule
`default_nettype wire
